### rtl/cfcr_pkg.sv
// Package: shared types, codes and constants for the CAN command frame receiver.
`default_nettype none
package cfcr_pkg;

   localparam int unsigned IdWidth      = 11;
   localparam int unsigned LimitWidth   = 8;
   localparam int unsigned PayloadWidth = 64;
   localparam int unsigned ValueWidth   = 16;
   localparam int unsigned CounterWidth = 4;
   localparam int unsigned CsrWidth     = 11;

   localparam logic [7:0]              CrcPoly         = 8'hD5;
   localparam logic [7:0]              CrcInit         = 8'hFF;
   localparam logic [IdWidth-1:0]      CommandIdReset  = 11'h3F5;
   localparam logic [LimitWidth-1:0]   TimeoutReset    = 8'd10;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_BUS_ERR = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      FAULT_NONE       = 3'd0,
      FAULT_CRC        = 3'd1,
      FAULT_TX_MISS    = 3'd2,
      FAULT_BUS        = 3'd3,
      FAULT_POWER_UP   = 3'd4,
      FAULT_NO_COMMAND = 3'd5,
      FAULT_BAD_VALUE  = 3'd6
   } fault_type;

   typedef enum logic {
      CSR_COMMAND_ID    = 1'b0,
      CSR_TIMEOUT_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type                  kind;
      logic [IdWidth-1:0]        frame_id;
      logic [PayloadWidth-1:0]   payload;
      logic                      tx_mailbox_free;
   } item_type;

   typedef struct packed {
      logic [2:0]                fault_code;
      logic [ValueWidth-1:0]     setpoint_a;
      logic [ValueWidth-1:0]     setpoint_b;
      logic                      frame_accepted;
   } result_type;

   typedef struct packed {
      logic [IdWidth-1:0]        command_id;
      logic [LimitWidth-1:0]     timeout_limit;
   } cfg_type;

   // One byte through the CRC register, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/cfcr_crc8.sv
// CRC-8 over payload bytes 6 down to 0.
`default_nettype none
module cfcr_crc8 (
   input  wire logic [cfcr_pkg::PayloadWidth-1:0] payload,
   output logic [7:0]                             crc
);
   import cfcr_pkg::*;

   always_comb begin
      logic [7:0] c;
      c = CrcInit;
      for (int k = 6; k >= 0; k--) begin
         c = crc8_byte(c, payload[8*k +: 8]);
      end
      crc = c;
   end

endmodule
`default_nettype wire

### rtl/cfcr_core.sv
// Receiver state and per-beat update: frame checks, tick timeout and mailbox check, bus error.
`default_nettype none
module cfcr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire cfcr_pkg::item_type   item,
   input  wire cfcr_pkg::cfg_type    cfg,
   output cfcr_pkg::result_type      result
);
   import cfcr_pkg::*;

   fault_type                 fault_ff,        fault_in;
   logic [ValueWidth-1:0]     value_a_ff,      value_a_in;
   logic [ValueWidth-1:0]     value_b_ff,      value_b_in;
   logic [CounterWidth-1:0]   last_counter_ff, last_counter_in;
   logic [LimitWidth-1:0]     tick_count_ff,   tick_count_in;

   logic [7:0]                crc;
   logic                      id_match;
   logic                      crc_ok;
   logic                      count_ok;
   logic                      accepted;
   logic [CounterWidth-1:0]   rx_counter;
   logic [ValueWidth-1:0]     rx_a;
   logic [ValueWidth-1:0]     rx_b;

   cfcr_crc8 u_crc8 (
      .payload (item.payload),
      .crc     (crc)
   );

   assign rx_counter = item.payload[32 +: CounterWidth];
   assign rx_a       = {item.payload[7:0],   item.payload[15:8]};
   assign rx_b       = {item.payload[23:16], item.payload[31:24]};
   assign id_match   = (item.kind == KIND_FRAME) && (item.frame_id == cfg.command_id);
   assign crc_ok     = (crc == item.payload[63:56]);
   assign count_ok   = (rx_counter == last_counter_ff + CounterWidth'(1));
   assign accepted   = id_match && crc_ok && count_ok;

   always_comb begin
      fault_in        = fault_ff;
      value_a_in      = value_a_ff;
      value_b_in      = value_b_ff;
      last_counter_in = last_counter_ff;
      tick_count_in   = tick_count_ff;
      case (item.kind)
         KIND_FRAME: begin
            if (id_match) begin
               if (crc_ok) begin
                  last_counter_in = rx_counter;
                  if (count_ok) begin
                     tick_count_in = '0;
                     if (item.payload[39]) begin
                        value_a_in = rx_a;
                        value_b_in = rx_b;
                     end else begin
                        fault_in   = ((rx_a == '0) && (rx_b == '0)) ? FAULT_NONE
                                                                    : FAULT_BAD_VALUE;
                        value_a_in = '0;
                        value_b_in = '0;
                     end
                  end
               end else begin
                  fault_in = FAULT_CRC;
               end
            end
         end
         KIND_TICK: begin
            if (!item.tx_mailbox_free) begin
               fault_in = FAULT_TX_MISS;
            end
            if (tick_count_ff == cfg.timeout_limit) begin
               fault_in = FAULT_NO_COMMAND;
            end else begin
               tick_count_in = tick_count_ff + LimitWidth'(1);
            end
         end
         KIND_BUS_ERR: begin
            fault_in = FAULT_BUS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff        <= FAULT_POWER_UP;
         value_a_ff      <= '0;
         value_b_ff      <= '0;
         last_counter_ff <= '0;
         tick_count_ff   <= '0;
      end else if (advance) begin
         fault_ff        <= fault_in;
         value_a_ff      <= value_a_in;
         value_b_ff      <= value_b_in;
         last_counter_ff <= last_counter_in;
         tick_count_ff   <= tick_count_in;
      end
   end

   assign result.fault_code     = fault_in;
   assign result.setpoint_a     = value_a_in;
   assign result.setpoint_b     = value_b_in;
   assign result.frame_accepted = accepted;

   a_accept_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      advance && accepted |=> tick_count_ff == '0)
      else $error("accepted frame left tick count non-zero");

   a_bus_error_fault: assert property (@(posedge clock) disable iff (reset)
      advance && item.kind == KIND_BUS_ERR |=> fault_ff == FAULT_BUS)
      else $error("bus error beat did not set bus fault");

   a_bad_crc_keeps_counter: assert property (@(posedge clock) disable iff (reset)
      advance && id_match && !crc_ok |=> $stable(last_counter_ff) && fault_ff == FAULT_CRC)
      else $error("bad crc frame changed counter or missed fault");

endmodule
`default_nettype wire

### rtl/can_command_frame_receiver_top.sv
// Top level: input stage, configuration registers, receiver core and result register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  kind, frame_id, payload, tx_mailbox_free
//   rsp      out        rsp_valid/rsp_ready  fault_code, setpoint_a, setpoint_b, frame_accepted
//   csr      in         csr_write_en         csr_index, csr_data
//
// One beat per cycle unless the result stalls; a result is registered behind the input stage.
// The CRC-8 over seven bytes is one XOR network between the input stage and the state.
// Sync active-high reset clears valids and state, sets power-up fault, loads config defaults.
// A stalled result holds the input stage, which holds req_ready low once full.
`default_nettype none
module can_command_frame_receiver_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_kind,
   input  wire logic [cfcr_pkg::IdWidth-1:0]        req_frame_id,
   input  wire logic [cfcr_pkg::PayloadWidth-1:0]   req_payload,
   input  wire logic                                req_tx_mailbox_free,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_fault_code,
   output logic [cfcr_pkg::ValueWidth-1:0]          rsp_setpoint_a,
   output logic [cfcr_pkg::ValueWidth-1:0]          rsp_setpoint_b,
   output logic                                     rsp_frame_accepted,
   input  wire logic                                csr_write_en,
   input  wire logic                                csr_index,
   input  wire logic [cfcr_pkg::CsrWidth-1:0]       csr_data
);
   import cfcr_pkg::*;

   logic        stage_vld_ff;
   item_type    stage_ff;
   logic        rsp_vld_ff;
   result_type  rsp_ff;
   cfg_type     cfg_ff;
   result_type  result;
   logic        advance;

   assign advance   = stage_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !stage_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_id    <= CommandIdReset;
         cfg_ff.timeout_limit <= TimeoutReset;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_COMMAND_ID:    cfg_ff.command_id    <= csr_data[IdWidth-1:0];
            CSR_TIMEOUT_LIMIT: cfg_ff.timeout_limit <= csr_data[LimitWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else if (req_ready) begin
         stage_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff.kind            <= kind_type'(req_kind);
         stage_ff.frame_id        <= req_frame_id;
         stage_ff.payload         <= req_payload;
         stage_ff.tx_mailbox_free <= req_tx_mailbox_free;
      end
   end

   cfcr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_fault_code     = rsp_ff.fault_code;
   assign rsp_setpoint_a     = rsp_ff.setpoint_a;
   assign rsp_setpoint_b     = rsp_ff.setpoint_b;
   assign rsp_frame_accepted = rsp_ff.frame_accepted;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff && !advance |=> stage_vld_ff && $stable(stage_ff))
      else $error("stalled input stage lost its beat");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("advanced beat did not reach the result register");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ready |=> rsp_vld_ff && $stable(rsp_ff))
      else $error("stalled result beat changed or dropped");

endmodule
`default_nettype wire
